// File: rtl/ssq_pkg.sv
`timescale 1ns / 1ps

package ssq_pkg;

    localparam int POS_W      = 24;
    localparam int US_PER_MS  = 1000;
    localparam int PRESC_W    = $clog2(US_PER_MS + 1);
    localparam int STEPS_W    = 13;
    localparam int INTERVAL_W = 17;
    localparam int RUN_W      = 21;
    localparam int TRAVEL_W   = 16;
    localparam int CYCLE_W    = 16;
    localparam int OP_W       = 3;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int DELTA_W    = TRAVEL_W + 2;
    localparam int SUM_W      = ((POS_W > DELTA_W) ? POS_W : DELTA_W) + 1;

    localparam logic [INTERVAL_W-1:0] STEP_TIMER_MAX = {INTERVAL_W{1'b1}};
    localparam logic [RUN_W-1:0]      RUN_MS_MAX     = {RUN_W{1'b1}};

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    localparam logic [STEPS_W-1:0]    TOP_RESET      = STEPS_W'(200);
    localparam logic [STEPS_W-1:0]    BOTTOM_RESET   = STEPS_W'(0);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(20000);
    localparam logic [RUN_W-1:0]      RUN_RESET      = RUN_W'(60000);
    localparam logic [STEPS_W-1:0]    NUDGE_RESET    = STEPS_W'(200);
    localparam logic [TRAVEL_W-1:0]   TRAVEL_RESET   = TRAVEL_W'(10000);
    localparam logic                  READY_RESET    = 1'b0;

    localparam logic signed [POS_W-1:0] POS_RESET =
        {{(POS_W-STEPS_W){1'b0}}, BOTTOM_RESET};

    typedef enum logic [OP_W-1:0] {
        OP_TICK,
        OP_HOME,
        OP_START,
        OP_PAUSE,
        OP_STOP,
        OP_NUDGE_UP,
        OP_NUDGE_DOWN,
        OP_TOGGLE
    } opcode_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE,
        MODE_HOME_TOP,
        MODE_HOME_BOTTOM,
        MODE_UP,
        MODE_DOWN,
        MODE_JOG,
        MODE_PAUSED,
        MODE_STOPPED
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP,
        CFG_BOTTOM,
        CFG_INTERVAL,
        CFG_RUN,
        CFG_NUDGE,
        CFG_TRAVEL,
        CFG_READY
    } cfg_idx_t;

    typedef struct packed {
        logic [STEPS_W-1:0]    top_steps;
        logic [STEPS_W-1:0]    bottom_steps;
        logic [INTERVAL_W-1:0] step_interval_us;
        logic [RUN_W-1:0]      run_duration_ms;
        logic [STEPS_W-1:0]    nudge_steps;
        logic [TRAVEL_W-1:0]   homing_travel_steps;
        logic                  driver_ready;
    } cfg_t;

    typedef struct packed {
        opcode_t opcode;
        logic    top_hit;
        logic    bot_hit;
    } item_t;

    typedef struct packed {
        logic                    step_pulse;
        logic                    direction;
        logic                    motor_enable;
        mode_t                   motion_mode;
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] target;
        logic [CYCLE_W-1:0]      cycles_done;
        logic [RUN_W-1:0]        elapsed_ms;
        logic                    sequence_on;
        logic                    top_hit;
        logic                    bottom_hit;
    } result_t;

    // Adds a signed offset to a position and clamps to the position range.
    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0]   a,
        input logic signed [DELTA_W-1:0] d
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(d);
        if (s > SUM_W'(POS_MAX)) begin
            return POS_MAX;
        end
        if (s < SUM_W'(POS_MIN)) begin
            return POS_MIN;
        end
        return s[POS_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] steps_to_pos(
        input logic [STEPS_W-1:0] v
    );
        return {{(POS_W-STEPS_W){1'b0}}, v};
    endfunction

endpackage

// File: rtl/ssq_cfg.sv
`timescale 1ns / 1ps

module ssq_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ssq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssq_pkg::CFG_DATA_W-1:0] cfg_data,
    output ssq_pkg::cfg_t                  cfg,
    output logic                           cfg_wr
);
    import ssq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_wr   = 1'b0;
        if (cfg_we)
        begin
            cfg_wr = 1'b1;
            case (cfg_idx_t'(cfg_index))
                CFG_TOP:      cfg_next.top_steps           = cfg_data[STEPS_W-1:0];
                CFG_BOTTOM:   cfg_next.bottom_steps        = cfg_data[STEPS_W-1:0];
                CFG_INTERVAL: cfg_next.step_interval_us    = cfg_data[INTERVAL_W-1:0];
                CFG_RUN:      cfg_next.run_duration_ms     = cfg_data[RUN_W-1:0];
                CFG_NUDGE:    cfg_next.nudge_steps         = cfg_data[STEPS_W-1:0];
                CFG_TRAVEL:   cfg_next.homing_travel_steps = cfg_data[TRAVEL_W-1:0];
                CFG_READY:    cfg_next.driver_ready        = cfg_data[0];
                default:      cfg_wr = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_steps           <= TOP_RESET;
            cfg_reg.bottom_steps        <= BOTTOM_RESET;
            cfg_reg.step_interval_us    <= INTERVAL_RESET;
            cfg_reg.run_duration_ms     <= RUN_RESET;
            cfg_reg.nudge_steps         <= NUDGE_RESET;
            cfg_reg.homing_travel_steps <= TRAVEL_RESET;
            cfg_reg.driver_ready        <= READY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/ssq_core.sv
`timescale 1ns / 1ps

module ssq_core (
    input  logic             clk,
    input  logic             rst_n,
    input  ssq_pkg::cfg_t    cfg,
    input  logic             cfg_wr,
    input  logic             advance,
    input  ssq_pkg::item_t   item,
    output ssq_pkg::result_t result
);
    import ssq_pkg::*;

    mode_t                   mode_reg, mode_next;
    mode_t                   resume_reg, resume_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic signed [POS_W-1:0] tgt_reg, tgt_next;
    logic [INTERVAL_W-1:0]   timer_reg, timer_next;
    logic                    motor_reg, motor_next;
    logic                    seq_reg, seq_next;
    logic [CYCLE_W-1:0]      cycle_reg, cycle_next;
    logic [PRESC_W-1:0]      presc_reg, presc_next;
    logic [RUN_W-1:0]        run_reg, run_next;
    logic                    swap_reg, swap_next;

    logic                    ready;
    logic [STEPS_W-1:0]      eff_top, eff_bot;
    logic signed [POS_W-1:0] top_pos, bot_pos, start_pos;
    logic signed [DELTA_W-1:0] travel_d, nudge_d;
    logic [PRESC_W-1:0]      presc_inc;
    logic                    do_move, do_halt, do_drive;
    mode_t                   halt_mode;
    logic signed [POS_W-1:0] move_tgt;
    logic                    step, step_dir;

    assign ready    = cfg.driver_ready;
    assign eff_top  = swap_reg ? cfg.bottom_steps : cfg.top_steps;
    assign eff_bot  = swap_reg ? cfg.top_steps : cfg.bottom_steps;
    assign top_pos  = steps_to_pos(eff_top);
    assign bot_pos  = steps_to_pos(eff_bot);
    // A start re-orders the sweep ends so that it always heads for the higher one.
    assign start_pos = (eff_top < eff_bot) ? bot_pos : top_pos;
    assign travel_d = {2'b00, cfg.homing_travel_steps};
    assign nudge_d  = {{(DELTA_W-STEPS_W){1'b0}}, cfg.nudge_steps};
    assign presc_inc = presc_reg + PRESC_W'(1);

    always_comb
    begin
        mode_next   = mode_reg;
        resume_next = resume_reg;
        pos_next    = pos_reg;
        tgt_next    = tgt_reg;
        timer_next  = timer_reg;
        motor_next  = motor_reg;
        seq_next    = seq_reg;
        cycle_next  = cycle_reg;
        presc_next  = presc_reg;
        run_next    = run_reg;
        swap_next   = swap_reg;
        do_move     = 1'b0;
        do_halt     = 1'b0;
        do_drive    = 1'b0;
        halt_mode   = MODE_IDLE;
        move_tgt    = pos_reg;
        step        = 1'b0;
        step_dir    = 1'b0;

        case (item.opcode)
            OP_TICK:
            begin
                if (ready)
                begin
                    if (timer_reg < STEP_TIMER_MAX)
                    begin
                        timer_next = timer_reg + INTERVAL_W'(1);
                    end
                    if (seq_reg && (mode_reg != MODE_PAUSED))
                    begin
                        if (presc_inc >= PRESC_W'(US_PER_MS))
                        begin
                            presc_next = '0;
                            if (run_reg < RUN_MS_MAX)
                            begin
                                run_next = run_reg + RUN_W'(1);
                            end
                        end
                        else
                        begin
                            presc_next = presc_inc;
                        end
                    end
                    if (seq_reg && (run_next >= cfg.run_duration_ms))
                    begin
                        do_halt   = 1'b1;
                        halt_mode = MODE_IDLE;
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_HOME_TOP:
                            begin
                                if (item.top_hit)
                                begin
                                    pos_next  = top_pos;
                                    do_move   = 1'b1;
                                    move_tgt  = sat_add(top_pos, -travel_d);
                                    mode_next = MODE_HOME_BOTTOM;
                                end
                                else
                                begin
                                    do_drive = 1'b1;
                                end
                            end
                            MODE_HOME_BOTTOM:
                            begin
                                if (item.bot_hit)
                                begin
                                    pos_next  = bot_pos;
                                    do_halt   = 1'b1;
                                    halt_mode = MODE_IDLE;
                                end
                                else
                                begin
                                    do_drive = 1'b1;
                                end
                            end
                            MODE_UP:
                            begin
                                if (item.top_hit || (tgt_reg == pos_reg))
                                begin
                                    if (item.top_hit)
                                    begin
                                        pos_next = top_pos;
                                    end
                                    do_move   = 1'b1;
                                    move_tgt  = bot_pos;
                                    mode_next = MODE_DOWN;
                                end
                                else
                                begin
                                    do_drive = 1'b1;
                                end
                            end
                            MODE_DOWN:
                            begin
                                if (item.bot_hit || (tgt_reg == pos_reg))
                                begin
                                    if (item.bot_hit)
                                    begin
                                        pos_next = bot_pos;
                                    end
                                    cycle_next = cycle_reg + CYCLE_W'(1);
                                    if (seq_reg)
                                    begin
                                        do_move   = 1'b1;
                                        move_tgt  = top_pos;
                                        mode_next = MODE_UP;
                                    end
                                    else
                                    begin
                                        do_halt   = 1'b1;
                                        halt_mode = MODE_IDLE;
                                    end
                                end
                                else
                                begin
                                    do_drive = 1'b1;
                                end
                            end
                            MODE_JOG:
                            begin
                                if (tgt_reg == pos_reg)
                                begin
                                    do_halt   = 1'b1;
                                    halt_mode = MODE_IDLE;
                                end
                                else
                                begin
                                    do_drive = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            OP_HOME:
            begin
                seq_next    = 1'b0;
                resume_next = MODE_IDLE;
                do_move     = 1'b1;
                move_tgt    = sat_add(pos_reg, travel_d);
                mode_next   = MODE_HOME_TOP;
            end
            OP_PAUSE:
            begin
                if (mode_reg == MODE_PAUSED)
                begin
                    if (ready)
                    begin
                        motor_next = 1'b1;
                    end
                    mode_next   = resume_reg;
                    resume_next = MODE_IDLE;
                    timer_next  = '0;
                end
                else if (mode_reg inside {[MODE_HOME_TOP:MODE_JOG]})
                begin
                    resume_next = mode_reg;
                    mode_next   = MODE_PAUSED;
                    if (ready)
                    begin
                        motor_next = 1'b0;
                    end
                end
            end
            OP_STOP:
            begin
                do_halt   = 1'b1;
                halt_mode = MODE_STOPPED;
            end
            OP_NUDGE_UP, OP_NUDGE_DOWN:
            begin
                seq_next    = 1'b0;
                resume_next = MODE_IDLE;
                do_move     = 1'b1;
                move_tgt    = sat_add(pos_reg,
                    (item.opcode == OP_NUDGE_UP) ? nudge_d : -nudge_d);
                mode_next   = MODE_JOG;
            end
            default:
            begin
                // Start, or the toggle: a toggle while a sequence runs or while paused stops; otherwise a sweep starts.
                if ((item.opcode == OP_TOGGLE) && (seq_reg || (mode_reg == MODE_PAUSED)))
                begin
                    do_halt   = 1'b1;
                    halt_mode = MODE_STOPPED;
                end
                else
                begin
                    if (eff_top < eff_bot)
                    begin
                        swap_next = ~swap_reg;
                    end
                    cycle_next  = '0;
                    seq_next    = 1'b1;
                    resume_next = MODE_IDLE;
                    run_next    = '0;
                    presc_next  = '0;
                    do_move     = 1'b1;
                    move_tgt    = start_pos;
                    mode_next   = MODE_UP;
                end
            end
        endcase

        if (do_move)
        begin
            tgt_next   = move_tgt;
            timer_next = '0;
            if (ready && (move_tgt != pos_next))
            begin
                motor_next = 1'b1;
            end
        end

        if (do_halt)
        begin
            seq_next    = 1'b0;
            mode_next   = halt_mode;
            resume_next = MODE_IDLE;
            tgt_next    = pos_next;
            run_next    = '0;
            presc_next  = '0;
            if (ready)
            begin
                motor_next = 1'b0;
            end
        end

        // One step toward the target once the interval has run out.
        if (do_drive && (tgt_reg != pos_reg))
        begin
            motor_next = 1'b1;
            if (timer_next >= cfg.step_interval_us)
            begin
                timer_next = '0;
                step       = 1'b1;
                step_dir   = (tgt_reg > pos_reg);
                pos_next   = (tgt_reg > pos_reg) ? (pos_reg + POS_W'(1))
                                                 : (pos_reg - POS_W'(1));
            end
        end
    end

    always_comb
    begin
        result.step_pulse   = step;
        result.direction    = step ? step_dir : (tgt_next >= pos_next);
        result.motor_enable = motor_next;
        result.motion_mode  = mode_next;
        result.position     = pos_next;
        result.target       = tgt_next;
        result.cycles_done  = cycle_next;
        result.elapsed_ms   = seq_next ? run_next : '0;
        result.sequence_on  = seq_next;
        result.top_hit      = item.top_hit;
        result.bottom_hit   = item.bot_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            resume_reg <= MODE_IDLE;
            pos_reg    <= POS_RESET;
            tgt_reg    <= POS_RESET;
            timer_reg  <= '0;
            motor_reg  <= 1'b0;
            seq_reg    <= 1'b0;
            cycle_reg  <= '0;
            presc_reg  <= '0;
            run_reg    <= '0;
            swap_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                mode_reg   <= mode_next;
                resume_reg <= resume_next;
                pos_reg    <= pos_next;
                tgt_reg    <= tgt_next;
                timer_reg  <= timer_next;
                motor_reg  <= motor_next;
                seq_reg    <= seq_next;
                cycle_reg  <= cycle_next;
                presc_reg  <= presc_next;
                run_reg    <= run_next;
            end
            if (cfg_wr)
            begin
                swap_reg <= 1'b0;
            end
            else if (advance)
            begin
                swap_reg <= swap_next;
            end
        end
    end

endmodule

// File: rtl/stepper_sweep_sequencer.sv
`timescale 1ns / 1ps

// Stepper sweep sequencer. Each accepted word is a 1 us tick or a command, and
// each yields exactly one result word. A word enters an input register, the
// sequencer state is updated from it once the output side can take the result,
// and the result lands in an output register. A new word is taken every clock
// as long as the output side keeps up; the rate is set by the state update,
// which has to finish before the next word can use the new state. Register
// writes go through the plain write port and are meant for times when no word
// is in flight; any write to a defined register also drops the top/bottom
// exchange that a start may have made. There is no clearing pass after reset.
module stepper_sweep_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ssq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssq_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ssq_pkg::OP_W-1:0]       opcode,
    input  logic                           top_level,
    input  logic                           bottom_level,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           step_pulse,
    output logic                           direction,
    output logic                           motor_enable,
    output logic [ssq_pkg::MODE_W-1:0]     motion_mode,
    output logic signed [ssq_pkg::POS_W-1:0] position,
    output logic signed [ssq_pkg::POS_W-1:0] target,
    output logic [ssq_pkg::CYCLE_W-1:0]    cycles_done,
    output logic [ssq_pkg::RUN_W-1:0]      elapsed_ms,
    output logic                           sequence_on,
    output logic                           top_hit,
    output logic                           bottom_hit
);
    import ssq_pkg::*;

    cfg_t    cfg;
    logic    cfg_wr;
    logic    in_valid_reg;
    item_t   item_reg;
    logic    advance;
    result_t result;
    logic    out_valid_reg;
    result_t out_reg;

    ssq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cfg_wr    (cfg_wr)
    );

    // The held word moves on whenever the output register is empty or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.opcode  <= opcode_t'(opcode);
            item_reg.top_hit <= ~top_level;
            item_reg.bot_hit <= ~bottom_level;
        end
    end

    ssq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr),
        .advance (advance),
        .item    (item_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign step_pulse   = out_reg.step_pulse;
    assign direction    = out_reg.direction;
    assign motor_enable = out_reg.motor_enable;
    assign motion_mode  = out_reg.motion_mode;
    assign position     = out_reg.position;
    assign target       = out_reg.target;
    assign cycles_done  = out_reg.cycles_done;
    assign elapsed_ms   = out_reg.elapsed_ms;
    assign sequence_on  = out_reg.sequence_on;
    assign top_hit      = out_reg.top_hit;
    assign bottom_hit   = out_reg.bottom_hit;

endmodule

// File: rtl/ssq_checker.sv
`timescale 1ns / 1ps

module ssq_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             step_pulse,
    input logic                             motor_enable,
    input logic [ssq_pkg::MODE_W-1:0]       motion_mode,
    input logic signed [ssq_pkg::POS_W-1:0] position,
    input logic signed [ssq_pkg::POS_W-1:0] target,
    input logic [ssq_pkg::RUN_W-1:0]        elapsed_ms,
    input logic                             sequence_on
);
    import ssq_pkg::*;

    // A stalled result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(position) && $stable(target))
    else $error("stalled result word changed");

    // Run time only shows while a sequence is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sequence_on |-> elapsed_ms == '0)
    else $error("elapsed time reported without an active sequence");

    // A step is only issued with the driver enabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_pulse |-> motor_enable)
    else $error("step issued with motor disabled");

    // Halting always parks the target on the current position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (motion_mode == MODE_IDLE || motion_mode == MODE_STOPPED)
        |-> (position == target) && !sequence_on)
    else $error("idle or stopped with motion pending");

endmodule

bind stepper_sweep_sequencer ssq_checker u_ssq_checker (.*);

// File: tb/sv/tb_stepper_sweep_sequencer.sv
`timescale 1ns / 1ps

module tb_stepper_sweep_sequencer;

    import ssq_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int PHASES = 12;

    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_sel;
        int unsigned          reg_val;
        opcode_t              op;
        logic                 top_lvl;
        logic                 bot_lvl;
        logic                 typed;
        result_t              want;
    } plan_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          opcode = OP_TICK;
    logic                     top_level = 1'b1;
    logic                     bottom_level = 1'b1;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     step_pulse;
    logic                     direction;
    logic                     motor_enable;
    logic [MODE_W-1:0]        motion_mode;
    logic signed [POS_W-1:0]  position;
    logic signed [POS_W-1:0]  target;
    logic [CYCLE_W-1:0]       cycles_done;
    logic [RUN_W-1:0]         elapsed_ms;
    logic                     sequence_on;
    logic                     top_hit;
    logic                     bottom_hit;

    stepper_sweep_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .top_level    (top_level),
        .bottom_level (bottom_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .step_pulse   (step_pulse),
        .direction    (direction),
        .motor_enable (motor_enable),
        .motion_mode  (motion_mode),
        .position     (position),
        .target       (target),
        .cycles_done  (cycles_done),
        .elapsed_ms   (elapsed_ms),
        .sequence_on  (sequence_on),
        .top_hit      (top_hit),
        .bottom_hit   (bottom_hit)
    );

    // Configuration as the sequencer should currently hold it.
    logic [STEPS_W-1:0]    top_cfg;
    logic [STEPS_W-1:0]    bottom_cfg;
    logic [INTERVAL_W-1:0] interval_cfg;
    logic [RUN_W-1:0]      run_limit_cfg;
    logic [STEPS_W-1:0]    nudge_cfg;
    logic [TRAVEL_W-1:0]   travel_cfg;
    logic                  ready_cfg;

    // Predicted motion state.
    mode_t                 cur_mode;
    mode_t                 held_mode;
    longint                cur_pos;
    longint                cur_target;
    int unsigned           step_wait;
    logic                  motor_lvl;
    logic                  seq_run;
    logic [CYCLE_W-1:0]    legs;
    int unsigned           presc;
    logic [RUN_W-1:0]      run_time;
    logic                  swapped;
    logic                  stepped;
    logic                  step_fwd;

    result_t               pending_status[$];
    plan_row_t             directed_plan[$];
    int unsigned           errors = 0;
    int unsigned           words_checked = 0;
    int unsigned           burst_left = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("stepper_sweep_sequencer test failed");
        $finish;
    end

    function automatic longint clamp_pos(longint v);
        if (v > longint'(POS_MAX))
        begin
            return longint'(POS_MAX);
        end
        if (v < longint'(POS_MIN))
        begin
            return longint'(POS_MIN);
        end
        return v;
    endfunction

    function automatic longint upper_end();
        return swapped ? longint'(bottom_cfg) : longint'(top_cfg);
    endfunction

    function automatic longint lower_end();
        return swapped ? longint'(top_cfg) : longint'(bottom_cfg);
    endfunction

    // The enable level only follows commands while the driver is ready.
    function automatic void drive_enable(logic en);
        if (ready_cfg)
        begin
            motor_lvl = en;
        end
    endfunction

    function automatic void halt_in(mode_t m);
        seq_run = 1'b0;
        cur_mode = m;
        held_mode = MODE_IDLE;
        cur_target = cur_pos;
        run_time = '0;
        presc = 0;
        drive_enable(1'b0);
    endfunction

    function automatic void aim_at(longint t);
        cur_target = clamp_pos(t);
        step_wait = 0;
        if (cur_target != cur_pos)
        begin
            drive_enable(1'b1);
        end
    endfunction

    function automatic void step_toward();
        if (cur_target == cur_pos)
        begin
            return;
        end
        drive_enable(1'b1);
        if (step_wait < interval_cfg)
        begin
            return;
        end
        step_wait = 0;
        stepped = 1'b1;
        step_fwd = cur_target > cur_pos;
        cur_pos += step_fwd ? 1 : -1;
    endfunction

    function automatic void begin_sweep();
        if (upper_end() < lower_end())
        begin
            swapped = ~swapped;
        end
        legs = '0;
        seq_run = 1'b1;
        held_mode = MODE_IDLE;
        run_time = '0;
        presc = 0;
        aim_at(upper_end());
        cur_mode = MODE_UP;
    endfunction

    function automatic void finish_leg();
        legs = legs + 1'b1;
        if (seq_run)
        begin
            aim_at(upper_end());
            cur_mode = MODE_UP;
        end
        else
        begin
            halt_in(MODE_IDLE);
        end
    endfunction

    function automatic void toggle_pause();
        if (cur_mode == MODE_PAUSED)
        begin
            drive_enable(1'b1);
            cur_mode = held_mode;
            held_mode = MODE_IDLE;
            step_wait = 0;
        end
        else if (cur_mode >= MODE_HOME_TOP && cur_mode <= MODE_JOG)
        begin
            held_mode = cur_mode;
            cur_mode = MODE_PAUSED;
            drive_enable(1'b0);
        end
    endfunction

    function automatic void nudge_by(longint d);
        seq_run = 1'b0;
        held_mode = MODE_IDLE;
        aim_at(cur_pos + d);
        cur_mode = MODE_JOG;
    endfunction

    function automatic void tick_time(logic th, logic bh);
        if (!ready_cfg)
        begin
            return;
        end
        if (step_wait < STEP_TIMER_MAX)
        begin
            step_wait++;
        end
        if (seq_run && cur_mode != MODE_PAUSED)
        begin
            presc++;
            if (presc >= US_PER_MS)
            begin
                presc = 0;
                if (run_time < RUN_MS_MAX)
                begin
                    run_time++;
                end
            end
        end
        if (seq_run && run_time >= run_limit_cfg)
        begin
            halt_in(MODE_IDLE);
            return;
        end
        case (cur_mode)
            MODE_HOME_TOP:
            begin
                if (th)
                begin
                    cur_pos = clamp_pos(upper_end());
                    aim_at(cur_pos - longint'(travel_cfg));
                    cur_mode = MODE_HOME_BOTTOM;
                end
                else
                begin
                    step_toward();
                end
            end
            MODE_HOME_BOTTOM:
            begin
                if (bh)
                begin
                    cur_pos = clamp_pos(lower_end());
                    cur_target = cur_pos;
                    halt_in(MODE_IDLE);
                end
                else
                begin
                    step_toward();
                end
            end
            MODE_UP:
            begin
                if (th)
                begin
                    cur_pos = clamp_pos(upper_end());
                    aim_at(lower_end());
                    cur_mode = MODE_DOWN;
                end
                else if (cur_target == cur_pos)
                begin
                    aim_at(lower_end());
                    cur_mode = MODE_DOWN;
                end
                else
                begin
                    step_toward();
                end
            end
            MODE_DOWN:
            begin
                if (bh)
                begin
                    cur_pos = clamp_pos(lower_end());
                    finish_leg();
                end
                else if (cur_target == cur_pos)
                begin
                    finish_leg();
                end
                else
                begin
                    step_toward();
                end
            end
            MODE_JOG:
            begin
                if (cur_target == cur_pos)
                begin
                    halt_in(MODE_IDLE);
                end
                else
                begin
                    step_toward();
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Advances the predicted state by one accepted word and returns its status.
    function automatic result_t next_motion_status(opcode_t op, logic tl, logic bl);
        result_t r;
        logic    th;
        logic    bh;
        th = ~tl;
        bh = ~bl;
        stepped = 1'b0;
        step_fwd = 1'b0;
        case (op)
            OP_TICK:
            begin
                tick_time(th, bh);
            end
            OP_HOME:
            begin
                seq_run = 1'b0;
                held_mode = MODE_IDLE;
                aim_at(cur_pos + longint'(travel_cfg));
                cur_mode = MODE_HOME_TOP;
            end
            OP_START:
            begin
                begin_sweep();
            end
            OP_PAUSE:
            begin
                toggle_pause();
            end
            OP_STOP:
            begin
                halt_in(MODE_STOPPED);
            end
            OP_NUDGE_UP:
            begin
                nudge_by(longint'(nudge_cfg));
            end
            OP_NUDGE_DOWN:
            begin
                nudge_by(-longint'(nudge_cfg));
            end
            OP_TOGGLE:
            begin
                if (seq_run || cur_mode == MODE_PAUSED)
                begin
                    halt_in(MODE_STOPPED);
                end
                else
                begin
                    begin_sweep();
                end
            end
            default:
            begin
            end
        endcase
        r.step_pulse = stepped;
        r.direction = stepped ? step_fwd : (cur_target >= cur_pos);
        r.motor_enable = motor_lvl;
        r.motion_mode = cur_mode;
        r.position = POS_W'(cur_pos);
        r.target = POS_W'(cur_target);
        r.cycles_done = legs;
        r.elapsed_ms = seq_run ? run_time : '0;
        r.sequence_on = seq_run;
        r.top_hit = th;
        r.bottom_hit = bh;
        return r;
    endfunction

    function automatic result_t at_rest(mode_t m, longint pos, longint tgt,
                                        logic th, logic bh);
        result_t r;
        r = '0;
        r.direction = (tgt >= pos);
        r.motion_mode = m;
        r.position = POS_W'(pos);
        r.target = POS_W'(tgt);
        r.top_hit = th;
        r.bottom_hit = bh;
        return r;
    endfunction

    function automatic plan_row_t word_row(opcode_t op, logic tl, logic bl);
        plan_row_t p;
        p.is_cfg = 1'b0;
        p.reg_sel = '0;
        p.reg_val = 0;
        p.op = op;
        p.top_lvl = tl;
        p.bot_lvl = bl;
        p.typed = 1'b0;
        p.want = '0;
        return p;
    endfunction

    function automatic plan_row_t seen_row(opcode_t op, logic tl, logic bl, result_t want);
        plan_row_t p;
        p = word_row(op, tl, bl);
        p.typed = 1'b1;
        p.want = want;
        return p;
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] sel, int unsigned val);
        plan_row_t p;
        p = word_row(OP_TICK, 1'b1, 1'b1);
        p.is_cfg = 1'b1;
        p.reg_sel = sel;
        p.reg_val = val;
        return p;
    endfunction

    function automatic int unsigned pick_steps();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(0, 8191);
        end
        return $urandom_range(0, 24);
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 50)
        begin
            $display("MISMATCH at word %0d: %s", words_checked, msg);
        end
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_status.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (sel)
            CFG_TOP:      top_cfg = STEPS_W'(val);
            CFG_BOTTOM:   bottom_cfg = STEPS_W'(val);
            CFG_INTERVAL: interval_cfg = INTERVAL_W'(val);
            CFG_RUN:      run_limit_cfg = RUN_W'(val);
            CFG_NUDGE:    nudge_cfg = STEPS_W'(val);
            CFG_TRAVEL:   travel_cfg = TRAVEL_W'(val);
            CFG_READY:    ready_cfg = val[0];
            default:
            begin
            end
        endcase
        // The spare index holds no register and leaves the exchange in place.
        if (sel != CFG_SPARE)
        begin
            swapped = 1'b0;
        end
    endtask

    // Sends one word in bursts separated by random gaps.
    task automatic send_word(opcode_t op, logic tl, logic bl, logic typed, result_t want);
        result_t guess;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode <= op;
        top_level <= tl;
        bottom_level <= bl;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        guess = next_motion_status(op, tl, bl);
        pending_status.push_back(typed ? want : guess);
    endtask

    initial
    begin
        int unsigned span;
        forever
        begin
            span = $urandom_range(10, 200);
            case ($urandom_range(0, 3))
                0:
                begin
                    repeat (span)
                    begin
                        @(posedge clk);
                        out_stall <= 1'b0;
                    end
                end
                1:
                begin
                    repeat (span)
                    begin
                        @(posedge clk);
                        out_stall <= ($urandom_range(0, 3) == 0);
                    end
                end
                2:
                begin
                    repeat (span)
                    begin
                        @(posedge clk);
                        out_stall <= ($urandom_range(0, 1) == 0);
                    end
                end
                default:
                begin
                    repeat (span)
                    begin
                        @(posedge clk);
                        out_stall <= ($urandom_range(0, 15) != 0);
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                report_mismatch("status word with no word pending");
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("step_pulse", step_pulse, want.step_pulse);
                check_field("direction", direction, want.direction);
                check_field("motor_enable", motor_enable, want.motor_enable);
                check_field("motion_mode", motion_mode, want.motion_mode);
                check_field("position", position, want.position);
                check_field("target", target, want.target);
                check_field("cycles_done", cycles_done, want.cycles_done);
                check_field("elapsed_ms", elapsed_ms, want.elapsed_ms);
                check_field("sequence_on", sequence_on, want.sequence_on);
                check_field("top_hit", top_hit, want.top_hit);
                check_field("bottom_hit", bottom_hit, want.bottom_hit);
            end
            words_checked++;
        end
    end

    initial
    begin
        plan_row_t   row;
        opcode_t     op;
        logic        tl;
        logic        bl;
        logic        hit;
        logic        busy;
        int unsigned span;
        int unsigned pct;
        int unsigned v_top;
        int unsigned v_bottom;
        int unsigned v_interval;
        int unsigned v_run;
        int unsigned v_nudge;
        int unsigned v_travel;
        int unsigned v_ready;

        top_cfg = TOP_RESET;
        bottom_cfg = BOTTOM_RESET;
        interval_cfg = INTERVAL_RESET;
        run_limit_cfg = RUN_RESET;
        nudge_cfg = NUDGE_RESET;
        travel_cfg = TRAVEL_RESET;
        ready_cfg = READY_RESET;
        cur_mode = MODE_IDLE;
        held_mode = MODE_IDLE;
        cur_pos = longint'(BOTTOM_RESET);
        cur_target = longint'(BOTTOM_RESET);
        step_wait = 0;
        motor_lvl = 1'b0;
        seq_run = 1'b0;
        legs = '0;
        presc = 0;
        run_time = '0;
        swapped = 1'b0;

        // Driver not ready: commands move the target and mode, ticks do nothing.
        directed_plan.push_back(seen_row(OP_TICK, 1'b1, 1'b1,
                                         at_rest(MODE_IDLE, 0, 0, 1'b0, 1'b0)));
        directed_plan.push_back(seen_row(OP_TICK, 1'b0, 1'b0,
                                         at_rest(MODE_IDLE, 0, 0, 1'b1, 1'b1)));
        directed_plan.push_back(seen_row(OP_NUDGE_UP, 1'b1, 1'b1,
                                         at_rest(MODE_JOG, 0, 200, 1'b0, 1'b0)));
        directed_plan.push_back(word_row(OP_TICK, 1'b1, 1'b0));
        directed_plan.push_back(seen_row(OP_NUDGE_DOWN, 1'b0, 1'b1,
                                         at_rest(MODE_JOG, 0, -200, 1'b1, 1'b0)));
        directed_plan.push_back(word_row(OP_PAUSE, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_PAUSE, 1'b1, 1'b1));
        directed_plan.push_back(seen_row(OP_STOP, 1'b1, 1'b1,
                                         at_rest(MODE_STOPPED, 0, 0, 1'b0, 1'b0)));
        directed_plan.push_back(word_row(OP_PAUSE, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_START, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_TOGGLE, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_TOGGLE, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_HOME, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_STOP, 1'b1, 1'b1));
        // Top below bottom forces the exchange at start; zero interval steps every tick.
        directed_plan.push_back(cfg_row(CFG_READY, 1));
        directed_plan.push_back(cfg_row(CFG_INTERVAL, 0));
        directed_plan.push_back(cfg_row(CFG_TOP, 3));
        directed_plan.push_back(cfg_row(CFG_BOTTOM, 5));
        directed_plan.push_back(cfg_row(CFG_RUN, 1));
        directed_plan.push_back(word_row(OP_START, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_TICK, 1'b0, 1'b1));
        directed_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_TICK, 1'b1, 1'b0));
        directed_plan.push_back(word_row(OP_PAUSE, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_PAUSE, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_NUDGE_DOWN, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1));
        // A zero run time ends the sequence on its first tick.
        directed_plan.push_back(cfg_row(CFG_RUN, 0));
        directed_plan.push_back(word_row(OP_START, 1'b1, 1'b1));
        directed_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[k])
        begin
            row = directed_plan[k];
            if (row.is_cfg)
            begin
                wait_drained();
                write_reg(row.reg_sel, row.reg_val);
            end
            else
            begin
                send_word(row.op, row.top_lvl, row.bot_lvl, row.typed, row.want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    // Long sweep whose run time expires at the first ms rollover.
                    v_top = $urandom_range(3, 10);
                    v_bottom = $urandom_range(0, 2);
                    v_interval = $urandom_range(0, 2);
                    v_run = 1;
                    v_nudge = 5;
                    v_travel = 8;
                    v_ready = 1;
                end
                1:
                begin
                    v_top = 8191;
                    v_bottom = 8191;
                    v_interval = 131071;
                    v_run = 2097151;
                    v_nudge = 8191;
                    v_travel = 65535;
                    v_ready = 1;
                end
                2:
                begin
                    v_top = 0;
                    v_bottom = 0;
                    v_interval = 0;
                    v_run = 0;
                    v_nudge = 0;
                    v_travel = 0;
                    v_ready = 1;
                end
                default:
                begin
                    v_top = pick_steps();
                    v_bottom = pick_steps();
                    v_nudge = pick_steps();
                    case ($urandom_range(0, 9))
                        0:       v_interval = 131071;
                        1:       v_interval = $urandom_range(2000, 100000);
                        default: v_interval = $urandom_range(0, 3);
                    endcase
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4: v_run = 0;
                        5:             v_run = 2097151;
                        6:             v_run = $urandom_range(15000, 1800000);
                        default:       v_run = $urandom_range(1, 3);
                    endcase
                    v_travel = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 30);
                    v_ready = ($urandom_range(0, 6) != 0) ? 1 : 0;
                end
            endcase
            write_reg(CFG_TOP, v_top);
            write_reg(CFG_BOTTOM, v_bottom);
            write_reg(CFG_INTERVAL, v_interval);
            write_reg(CFG_RUN, v_run);
            write_reg(CFG_NUDGE, v_nudge);
            write_reg(CFG_TRAVEL, v_travel);
            write_reg(CFG_READY, v_ready);

            span = (ph == 0) ? 1010 : $urandom_range(10, 30);
            pct = (ph == 0) ? 0 : $urandom_range(4, 20);
            if (ph == 0)
            begin
                send_word(OP_START, 1'b1, 1'b1, 1'b0, '0);
            end

            repeat (span)
            begin
                busy = (cur_mode != MODE_IDLE && cur_mode != MODE_STOPPED);
                if ($urandom_range(0, 99) < (busy ? pct : ((ph == 0) ? 0 : 25)))
                begin
                    if (!busy && $urandom_range(0, 1) == 0)
                    begin
                        op = ($urandom_range(0, 3) == 0) ? OP_HOME : OP_START;
                    end
                    else
                    begin
                        op = opcode_t'($urandom_range(1, 7));
                    end
                    tl = 1'($urandom_range(0, 1));
                    bl = 1'($urandom_range(0, 1));
                end
                else
                begin
                    // Limit switches mostly follow the predicted carriage position,
                    // with an occasional spurious level.
                    op = OP_TICK;
                    hit = (cur_pos >= upper_end()) && ($urandom_range(0, 3) != 0);
                    if ($urandom_range(0, 31) == 0)
                    begin
                        hit = ~hit;
                    end
                    tl = ~hit;
                    hit = (cur_pos <= lower_end()) && ($urandom_range(0, 3) != 0);
                    if ($urandom_range(0, 31) == 0)
                    begin
                        hit = ~hit;
                    end
                    bl = ~hit;
                end
                send_word(op, tl, bl, 1'b0, '0);
                if ($urandom_range(0, 199) == 0)
                begin
                    wait_drained();
                    if ($urandom_range(0, 1) == 0)
                    begin
                        write_reg(CFG_SPARE, $urandom);
                    end
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_status.size() == 0)
        begin
            $display("stepper_sweep_sequencer test passed");
        end
        else
        begin
            $display("stepper_sweep_sequencer test failed");
        end
        $finish;
    end

endmodule
